[sv/bwts_pkg.sv]
// bwts_pkg: shared constants, register codes and elaboration-time color tables
// for the bilinear wrap texture sampler; depends on nothing
package bwts_pkg;

  localparam int DefMaxWidth   = 256;
  localparam int DefMaxHeight  = 256;
  localparam int DefLinearBits = 16;

  localparam int LinMaxW      = 24;
  localparam int CodeW        = 8;
  localparam int NumCodes     = 256;
  localparam int NumTaps      = 4;
  localparam int NumChan      = 4;
  localparam int AlphaCh      = 3;
  localparam int FracBits     = 16;
  localparam int ModPerStage  = 2;
  localparam int ModStages    = FracBits / ModPerStage;
  localparam int SrchPerStage = 2;
  localparam int SrchStages   = CodeW / SrchPerStage;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 9;
  localparam int SizeRegW     = 9;
  localparam int LinCodes     = 10;

  localparam int TapTopLeft  = 0;
  localparam int TapTopRight = 1;
  localparam int TapBotLeft  = 2;
  localparam int TapBotRight = 3;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpSample = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    RegWidth,
    RegHeight,
    RegFlipRows,
    RegForceOpaque
  } cfg_reg_e;

  typedef logic [NumCodes-1:0][LinMaxW-1:0] lin_tab_t;

  localparam logic [63:0] DecDen = 64'd269025;
  localparam logic [63:0] EncDen = 64'd539105;
  localparam logic [63:0] OneQ30 = 64'd1 << 30;

  // (num/den)^2.4 in q30, den picked by enc
  function automatic logic [63:0] pow24_q30(input logic [63:0] num, input logic enc);
    logic [63:0] t, q, lo, hi, mid, r2, r4, r5;
    t = enc ? (num << 30) / EncDen : (num << 30) / DecDen;
    if (t > OneQ30) t = OneQ30;
    q  = (t * t) >> 30;
    lo = '0;
    hi = OneQ30;
    for (int i = 0; i < 32; i++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        r2  = (mid * mid) >> 30;
        r4  = (r2 * r2) >> 30;
        r5  = (r4 * mid) >> 30;
        if (r5 <= q) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    return (q * lo) >> 30;
  endfunction

  function automatic lin_tab_t dec_color_tab(input int lin_bits);
    lin_tab_t    tab;
    logic [63:0] m, v, p;
    m = (64'd1 << lin_bits) - 64'd1;
    for (int k = 0; k < NumCodes; k++) begin
      if (k <= LinCodes) begin
        v = (64'd200 * 64'(k) * m + 64'd329460) / 64'd658920;
      end else begin
        p = pow24_q30(64'd1000 * 64'(k) + 64'd14025, 1'b0);
        v = (p * m + (OneQ30 >> 1)) >> 30;
      end
      tab[k] = v[LinMaxW-1:0];
    end
    return tab;
  endfunction

  function automatic lin_tab_t enc_color_tab(input int lin_bits);
    lin_tab_t    tab;
    logic [63:0] m, v, p;
    m = (64'd1 << lin_bits) - 64'd1;
    for (int k = 0; k < NumCodes; k++) begin
      if (k <= LinCodes) begin
        v = (64'd200 * 64'(k) * m + 64'd660211) / 64'd660212;
      end else begin
        p = pow24_q30(64'd2000 * 64'(k) + 64'd28105, 1'b1);
        v = (p * m + OneQ30 - 64'd1) >> 30;
      end
      tab[k] = v[LinMaxW-1:0];
    end
    return tab;
  endfunction

  function automatic lin_tab_t dec_alpha_tab(input int lin_bits);
    lin_tab_t    tab;
    logic [63:0] m, v;
    m = (64'd1 << lin_bits) - 64'd1;
    for (int k = 0; k < NumCodes; k++) begin
      v      = (64'(k) * m + 64'd127) / 64'd255;
      tab[k] = v[LinMaxW-1:0];
    end
    return tab;
  endfunction

  function automatic lin_tab_t enc_alpha_tab(input int lin_bits);
    lin_tab_t    tab;
    logic [63:0] m, v;
    m = (64'd1 << lin_bits) - 64'd1;
    for (int k = 0; k < NumCodes; k++) begin
      v      = (64'd2 * m * 64'(k) + 64'd510) / 64'd511;
      tab[k] = v[LinMaxW-1:0];
    end
    return tab;
  endfunction

endpackage

[sv/bwts_if.sv]
// bwts_if: valid/ready channel interfaces for sampler input, output and config
// depends on bwts_pkg
interface bwts_in_if import bwts_pkg::*;;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [7:0]         texel_x;
  logic [7:0]         texel_y;
  logic [7:0]         red_in;
  logic [7:0]         green_in;
  logic [7:0]         blue_in;
  logic [7:0]         alpha_in;
  logic signed [31:0] u_coord;
  logic signed [31:0] v_coord;

  modport source(output valid, operation, texel_x, texel_y, red_in, green_in, blue_in,
                 alpha_in, u_coord, v_coord, input ready);
  modport sink(input valid, operation, texel_x, texel_y, red_in, green_in, blue_in,
               alpha_in, u_coord, v_coord, output ready);
endinterface

interface bwts_out_if import bwts_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;

  modport source(output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink(input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

interface bwts_cfg_if import bwts_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[sv/bwts_texel_store.sv]
// bwts_texel_store: texel memory, a copy per bilinear tap, four reads per enabled cycle
// depends on bwts_pkg
module bwts_texel_store import bwts_pkg::*; #(
  parameter int  DEPTH  = DefMaxWidth * DefMaxHeight,
  parameter int  DATA_W = NumChan * DefLinearBits,
  localparam int AddrW  = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [AddrW-1:0]  raddr_i [NumTaps],
  output logic [DATA_W-1:0] rdata_o [NumTaps]
);

  for (genvar t = 0; t < NumTaps; t++) begin : g_copy
    logic [DATA_W-1:0] mem [DEPTH];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (we_i) mem[waddr_i] <= wdata_i;
        rdata_o[t] <= mem[raddr_i[t]];
      end
    end
  end

endmodule

[sv/bilinear_wrap_texture_sampler_unit.sv]
// bilinear_wrap_texture_sampler_unit: top level, sRGB texel load and wrapped bilinear sample
// depends on bwts_pkg, bwts_if and bwts_texel_store
// a load gives no result; a sample passes stages a, m, r, e, g, s and the output register
// throughput: one beat per cycle, loads and samples mixed freely; the whole pipe stalls
// together while the output register holds an untaken result
// reset clears all valid bits and sets width 256, height 256, no flip, no forced alpha;
// texel memory contents are undefined until loaded
module bilinear_wrap_texture_sampler_unit import bwts_pkg::*; #(
  parameter int MAX_WIDTH   = DefMaxWidth,
  parameter int MAX_HEIGHT  = DefMaxHeight,
  parameter int LINEAR_BITS = DefLinearBits
) (
  input logic      clk_i,
  input logic      rst_ni,
  bwts_cfg_if.sink cfg_i,
  bwts_in_if.sink  in_i,
  bwts_out_if.source out_o
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int LB    = LINEAR_BITS;
  localparam int DW    = NumChan * LB;
  localparam int PUW   = 32 + WW + 1;
  localparam int PVW   = 32 + HW + 1;
  localparam int MUW   = FracBits + WW;
  localparam int MVW   = FracBits + HW;
  localparam int LPW   = LB + FracBits + 2;

  localparam lin_tab_t DecColorTab = dec_color_tab(LINEAR_BITS);
  localparam lin_tab_t DecAlphaTab = dec_alpha_tab(LINEAR_BITS);
  localparam lin_tab_t EncColorTab = enc_color_tab(LINEAR_BITS);
  localparam lin_tab_t EncAlphaTab = enc_alpha_tab(LINEAR_BITS);

  function automatic logic [LB-1:0] lerp(input logic [LB-1:0] a, input logic [LB-1:0] b,
                                         input logic [FracBits-1:0] f);
    logic signed [LB:0]    diff;
    logic signed [LPW-1:0] prod;
    logic signed [LPW-1:0] sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = LPW'(diff) * LPW'($signed({1'b0, f}));
    sum  = LPW'($signed({1'b0, a})) + (prod >>> FracBits);
    return sum[LB-1:0];
  endfunction

  // configuration
  logic [SizeRegW-1:0] width_q, height_q;
  logic                flip_q, opaque_q;
  logic [WW-1:0]       w_eff;
  logic [HW-1:0]       h_eff;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SizeRegW'(256);
      height_q <= SizeRegW'(256);
      flip_q   <= 1'b0;
      opaque_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        RegWidth:       width_q  <= cfg_i.data[SizeRegW-1:0];
        RegHeight:      height_q <= cfg_i.data[SizeRegW-1:0];
        RegFlipRows:    flip_q   <= cfg_i.data[0];
        RegForceOpaque: opaque_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) w_eff = WW'(1);
    else if (32'(width_q) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(width_q);
    if (height_q == '0) h_eff = HW'(1);
    else if (32'(height_q) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(height_q);
  end

  // pipeline advance
  logic out_vld_q;
  logic adv, acc;

  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;
  assign acc        = in_i.valid && adv;

  // stage a: decode, bounds, write address, coordinate scaling
  logic                  vld_a_q, smp_a_q, we_a_q;
  logic [AW-1:0]         waddr_a_q;
  logic [DW-1:0]         wdata_a_q;
  logic signed [PUW-1:0] prod_u_q;
  logic signed [PVW-1:0] prod_v_q;
  logic                  inb;
  logic [31:0]           row;

  always_comb begin
    inb = (32'(in_i.texel_x) < 32'(w_eff)) && (32'(in_i.texel_y) < 32'(h_eff));
    row = flip_q ? 32'(h_eff) - 32'd1 - 32'(in_i.texel_y) : 32'(in_i.texel_y);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      smp_a_q   <= (in_i.operation == OpSample);
      we_a_q    <= (in_i.operation == OpLoad) && inb;
      waddr_a_q <= AW'(row * MAX_WIDTH + 32'(in_i.texel_x));
      wdata_a_q <= {DecAlphaTab[in_i.alpha_in][LB-1:0], DecColorTab[in_i.blue_in][LB-1:0],
                    DecColorTab[in_i.green_in][LB-1:0], DecColorTab[in_i.red_in][LB-1:0]};
      prod_u_q  <= PUW'(in_i.u_coord) * PUW'($signed({1'b0, w_eff}));
      prod_v_q  <= PVW'(in_i.v_coord) * PVW'($signed({1'b0, h_eff}));
    end
  end

  // wrap modulo, restoring steps
  logic                vld_m_q   [ModStages+1];
  logic                smp_m_q   [ModStages+1];
  logic                we_m_q    [ModStages+1];
  logic [AW-1:0]       waddr_m_q [ModStages+1];
  logic [DW-1:0]       wdata_m_q [ModStages+1];
  logic [FracBits-1:0] fu_m_q    [ModStages+1];
  logic [FracBits-1:0] fv_m_q    [ModStages+1];
  logic [MUW-1:0]      ru_m_q    [ModStages+1];
  logic [MVW-1:0]      rv_m_q    [ModStages+1];
  logic [MUW-1:0]      ru_nx     [ModStages+1];
  logic [MVW-1:0]      rv_nx     [ModStages+1];

  always_comb begin
    ru_nx[0] = MUW'(prod_u_q >>> FracBits) + (MUW'(w_eff) << (FracBits - 1));
    rv_nx[0] = MVW'(prod_v_q >>> FracBits) + (MVW'(h_eff) << (FracBits - 1));
    for (int k = 1; k <= ModStages; k++) begin
      ru_nx[k] = ru_m_q[k-1];
      rv_nx[k] = rv_m_q[k-1];
      for (int j = 0; j < ModPerStage; j++) begin
        if (ru_nx[k] >= (MUW'(w_eff) << (FracBits - 1 - (k - 1) * ModPerStage - j)))
          ru_nx[k] = ru_nx[k] - (MUW'(w_eff) << (FracBits - 1 - (k - 1) * ModPerStage - j));
        if (rv_nx[k] >= (MVW'(h_eff) << (FracBits - 1 - (k - 1) * ModPerStage - j)))
          rv_nx[k] = rv_nx[k] - (MVW'(h_eff) << (FracBits - 1 - (k - 1) * ModPerStage - j));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      smp_m_q[0]   <= smp_a_q;
      we_m_q[0]    <= we_a_q;
      waddr_m_q[0] <= waddr_a_q;
      wdata_m_q[0] <= wdata_a_q;
      fu_m_q[0]    <= prod_u_q[FracBits-1:0];
      fv_m_q[0]    <= prod_v_q[FracBits-1:0];
      for (int k = 1; k <= ModStages; k++) begin
        smp_m_q[k]   <= smp_m_q[k-1];
        we_m_q[k]    <= we_m_q[k-1];
        waddr_m_q[k] <= waddr_m_q[k-1];
        wdata_m_q[k] <= wdata_m_q[k-1];
        fu_m_q[k]    <= fu_m_q[k-1];
        fv_m_q[k]    <= fv_m_q[k-1];
      end
      for (int k = 0; k <= ModStages; k++) begin
        ru_m_q[k] <= ru_nx[k];
        rv_m_q[k] <= rv_nx[k];
      end
    end
  end

  // stage r: neighbor wrap and tap addresses
  logic                vld_r_q, smp_r_q, we_r_q;
  logic [AW-1:0]       waddr_r_q;
  logic [DW-1:0]       wdata_r_q;
  logic [FracBits-1:0] fu_r_q, fv_r_q;
  logic [AW-1:0]       raddr_r_q [NumTaps];
  logic [XW-1:0]       x0, x1;
  logic [YW-1:0]       y0, y1;

  always_comb begin
    x0 = XW'(ru_m_q[ModStages]);
    y0 = YW'(rv_m_q[ModStages]);
    if (32'(x0) + 32'd1 == 32'(w_eff)) x1 = '0;
    else x1 = x0 + XW'(1);
    if (32'(y0) + 32'd1 == 32'(h_eff)) y1 = '0;
    else y1 = y0 + YW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      smp_r_q   <= smp_m_q[ModStages];
      we_r_q    <= we_m_q[ModStages];
      waddr_r_q <= waddr_m_q[ModStages];
      wdata_r_q <= wdata_m_q[ModStages];
      fu_r_q    <= fu_m_q[ModStages];
      fv_r_q    <= fv_m_q[ModStages];
      raddr_r_q[TapTopLeft]  <= AW'(32'(y0) * MAX_WIDTH + 32'(x0));
      raddr_r_q[TapTopRight] <= AW'(32'(y0) * MAX_WIDTH + 32'(x1));
      raddr_r_q[TapBotLeft]  <= AW'(32'(y1) * MAX_WIDTH + 32'(x0));
      raddr_r_q[TapBotRight] <= AW'(32'(y1) * MAX_WIDTH + 32'(x1));
    end
  end

  // stage e: texel memory, loads write and samples read at the same point
  logic                vld_e_q, smp_e_q;
  logic [FracBits-1:0] fu_e_q, fv_e_q;
  logic [DW-1:0]       rdata [NumTaps];
  logic                st_we;

  assign st_we = vld_r_q && we_r_q;

  bwts_texel_store #(
    .DEPTH  (Depth),
    .DATA_W (DW)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (adv),
    .we_i    (st_we),
    .waddr_i (waddr_r_q),
    .wdata_i (wdata_r_q),
    .raddr_i (raddr_r_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      smp_e_q <= smp_r_q;
      fu_e_q  <= fu_r_q;
      fv_e_q  <= fv_r_q;
    end
  end

  // stage g: horizontal lerps
  logic                vld_g_q, smp_g_q;
  logic [FracBits-1:0] fv_g_q;
  logic [LB-1:0]       top_g_q [NumChan];
  logic [LB-1:0]       bot_g_q [NumChan];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      smp_g_q <= smp_e_q;
      fv_g_q  <= fv_e_q;
      for (int c = 0; c < NumChan; c++) begin
        top_g_q[c] <= lerp(rdata[TapTopLeft][c*LB +: LB], rdata[TapTopRight][c*LB +: LB],
                           fu_e_q);
        bot_g_q[c] <= lerp(rdata[TapBotLeft][c*LB +: LB], rdata[TapBotRight][c*LB +: LB],
                           fu_e_q);
      end
    end
  end

  // vertical lerp, then threshold search two code bits per stage
  logic             vld_s_q  [SrchStages+1];
  logic             smp_s_q  [SrchStages+1];
  logic [LB-1:0]    lin_s_q  [SrchStages+1][NumChan];
  logic [CodeW-1:0] code_s_q [SrchStages+1][NumChan];
  logic [CodeW-1:0] code_nx  [SrchStages+1][NumChan];
  logic [CodeW-1:0] cand;
  logic [LB-1:0]    thr;

  always_comb begin
    cand = '0;
    thr  = '0;
    for (int c = 0; c < NumChan; c++) begin
      code_nx[0][c] = '0;
      for (int k = 1; k <= SrchStages; k++) begin
        code_nx[k][c] = code_s_q[k-1][c];
        for (int j = 0; j < SrchPerStage; j++) begin
          cand = code_nx[k][c] | (CodeW'(1) << (CodeW - 1 - (k - 1) * SrchPerStage - j));
          thr  = (c == AlphaCh) ? EncAlphaTab[cand][LB-1:0] : EncColorTab[cand][LB-1:0];
          if (thr <= lin_s_q[k-1][c]) code_nx[k][c] = cand;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      smp_s_q[0] <= smp_g_q;
      for (int c = 0; c < NumChan; c++) begin
        lin_s_q[0][c] <= lerp(top_g_q[c], bot_g_q[c], fv_g_q);
      end
      for (int k = 1; k <= SrchStages; k++) begin
        smp_s_q[k] <= smp_s_q[k-1];
        for (int c = 0; c < NumChan; c++) begin
          lin_s_q[k][c] <= lin_s_q[k-1][c];
        end
      end
      for (int k = 0; k <= SrchStages; k++) begin
        for (int c = 0; c < NumChan; c++) begin
          code_s_q[k][c] <= code_nx[k][c];
        end
      end
    end
  end

  // output register
  logic [CodeW-1:0] out_q [NumChan];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < NumChan; c++) begin
        out_q[c] <= code_s_q[SrchStages][c];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q   <= 1'b0;
      vld_r_q   <= 1'b0;
      vld_e_q   <= 1'b0;
      vld_g_q   <= 1'b0;
      out_vld_q <= 1'b0;
      for (int k = 0; k <= ModStages; k++) vld_m_q[k] <= 1'b0;
      for (int k = 0; k <= SrchStages; k++) vld_s_q[k] <= 1'b0;
    end else if (adv) begin
      vld_a_q    <= acc;
      vld_m_q[0] <= vld_a_q;
      for (int k = 1; k <= ModStages; k++) vld_m_q[k] <= vld_m_q[k-1];
      vld_r_q    <= vld_m_q[ModStages];
      vld_e_q    <= vld_r_q;
      vld_g_q    <= vld_e_q;
      vld_s_q[0] <= vld_g_q;
      for (int k = 1; k <= SrchStages; k++) vld_s_q[k] <= vld_s_q[k-1];
      out_vld_q  <= vld_s_q[SrchStages] && smp_s_q[SrchStages];
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.red_out   = out_q[0];
  assign out_o.green_out = out_q[1];
  assign out_o.blue_out  = out_q[2];
  assign out_o.alpha_out = opaque_q ? 8'hFF : out_q[AlphaCh];

  // checks
  a_write_is_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |-> !smp_r_q)
    else $error("texel write issued by a sample beat");

  a_result_from_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(vld_s_q[SrchStages] && smp_s_q[SrchStages]))
    else $error("result raised without a sample at the end of the pipe");

  a_stall_holds_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_r_q && !adv) |=> (vld_r_q && $stable(raddr_r_q[TapTopLeft])))
    else $error("read stage moved during a stall");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> vld_a_q)
    else $error("accepted beat missing from first stage");

endmodule
